### rtl/semver_stream_compare_macros.svh
// assertion macros for the version compare block
// expects i_clk and i_rst_n in the scope where the macros are used
`ifndef SEMVER_STREAM_COMPARE_MACROS_SVH
`define SEMVER_STREAM_COMPARE_MACROS_SVH

`ifndef ASSERT_OFF
`define SSC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("semver_stream_compare: check failed");
`define SSC_NEVER(lbl, cond) \
    `SSC_ASSERT(lbl, !(cond))
`else
`define SSC_ASSERT(lbl, prop)
`define SSC_NEVER(lbl, cond)
`endif

`endif

### rtl/ssc_pkg.sv
// shared types and constants of the version string compare block
// no dependencies
package ssc_pkg;

    localparam int CHAR_W = 8;
    localparam int NUM_W  = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_V    = 8'h76;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2e;
    localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2d;

    // component flags: bit 0 digit seen, bit 1 first digit was zero
    localparam logic [1:0] FLAG_NONE      = 2'b00;
    localparam logic [1:0] FLAG_DIGIT     = 2'b01;
    localparam logic [1:0] FLAG_LEAD_ZERO = 2'b11;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_MAJOR = 3'd1,
        PH_MINOR = 3'd2,
        PH_PATCH = 3'd3,
        PH_DONE  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        REG_LATEST_NEEDS_V        = 2'd0,
        REG_LATEST_ALLOWS_SUFFIX  = 2'd1,
        REG_RUNNING_NEEDS_V       = 2'd2,
        REG_RUNNING_ALLOWS_SUFFIX = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic is_newer;
        logic latest_valid;
        logic running_valid;
    } t_result;

endpackage

### rtl/ssc_in_if.sv
// input byte channel of the version compare block
// depends on ssc_pkg for the character width
interface ssc_in_if;
    logic                      valid;
    logic                      ready;
    logic [ssc_pkg::CHAR_W-1:0] char_code;
    logic                      string_sel;
    logic                      last_byte;

    modport source (output valid, output char_code, output string_sel, output last_byte,
                    input ready);
    modport sink (input valid, input char_code, input string_sel, input last_byte,
                  output ready);
endinterface

### rtl/ssc_out_if.sv
// result channel of the version compare block
// no dependencies
interface ssc_out_if;
    logic valid;
    logic ready;
    logic is_newer;
    logic latest_valid;
    logic running_valid;

    modport source (output valid, output is_newer, output latest_valid, output running_valid,
                    input ready);
    modport sink (input valid, input is_newer, input latest_valid, input running_valid,
                  output ready);
endinterface

### rtl/semver_stream_compare.sv
// Version string compare. Takes one byte of a vMAJOR.MINOR.PATCH string per
// cycle unless input is stalled, the latest string first and the running string
// after it, and gives one result per running string, registered in the result
// register or, while that is full and not being read, in the skid. The decimal
// accumulator (multiply by ten, add the digit, check the 32-bit bound) feeds
// the parser state in the same cycle, and the patch compare on the last byte
// feeds the result. A two-entry output stage (result register plus skid) lets input
// flow while a result waits; input stalls only when both entries are full.
// Config registers: 0 latest_needs_v, 1 latest_allows_suffix,
// 2 running_needs_v, 3 running_allows_suffix, bit 0 at byte addresses 0..12.
// depends on ssc_pkg, ssc_in_if, ssc_out_if and the macro header
`include "semver_stream_compare_macros.svh"

module semver_stream_compare (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ssc_in_if.sink                      i_in,
    ssc_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ssc_pkg::ADDR_W-1:0]  paddr,
    input  logic [ssc_pkg::DATA_W-1:0]  pwdata,
    output logic [ssc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import ssc_pkg::*;

    // configuration
    logic r_latest_needs_v, r_latest_allows_suffix;
    logic r_running_needs_v, r_running_allows_suffix;

    // parser state
    t_phase           r_phase, s_phase, n_phase;
    logic [NUM_W-1:0] r_accum, s_accum, n_accum;
    logic [1:0]       r_flags, s_flags, n_flags;
    logic             r_failed, s_failed, n_failed;
    logic [NUM_W-1:0] r_lat_fields [3];
    logic [NUM_W-1:0] s_lat_fields [3];
    logic [NUM_W-1:0] r_run_fields [2];
    logic [NUM_W-1:0] s_run_fields [2];
    logic             r_lat_ok, n_lat_ok;

    // output stage
    t_result r_out, r_skid, res_data;
    logic    r_out_valid, r_skid_valid;
    logic    res_fire;

    logic accept, out_fire, cfg_write;
    logic needs_v, allow_sfx;
    logic [CHAR_W-1:0] c;

    assign c         = i_in.char_code;
    assign accept    = i_in.valid && i_in.ready;
    assign out_fire  = r_out_valid && o_out.ready;
    assign i_in.ready = !r_skid_valid;
    assign needs_v   = i_in.string_sel ? r_running_needs_v : r_latest_needs_v;
    assign allow_sfx = i_in.string_sel ? r_running_allows_suffix : r_latest_allows_suffix;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (t_reg_idx'(paddr[3:2]))
            REG_LATEST_NEEDS_V:        prdata[0] = r_latest_needs_v;
            REG_LATEST_ALLOWS_SUFFIX:  prdata[0] = r_latest_allows_suffix;
            REG_RUNNING_NEEDS_V:       prdata[0] = r_running_needs_v;
            REG_RUNNING_ALLOWS_SUFFIX: prdata[0] = r_running_allows_suffix;
            default:                   prdata    = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latest_needs_v        <= 1'b1;
            r_latest_allows_suffix  <= 1'b0;
            r_running_needs_v       <= 1'b0;
            r_running_allows_suffix <= 1'b1;
        end else if (cfg_write) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_LATEST_NEEDS_V:        r_latest_needs_v        <= pwdata[0];
                REG_LATEST_ALLOWS_SUFFIX:  r_latest_allows_suffix  <= pwdata[0];
                REG_RUNNING_NEEDS_V:       r_running_needs_v       <= pwdata[0];
                REG_RUNNING_ALLOWS_SUFFIX: r_running_allows_suffix <= pwdata[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- parser step
    // s_* is the state after this byte (and a string end) before any restart
    always_comb begin
        logic [NUM_W+3:0] prod;
        logic [1:0]       idx;
        logic             skip;
        logic             is_digit;
        logic             do_end;

        s_phase      = r_phase;
        s_accum      = r_accum;
        s_flags      = r_flags;
        s_failed     = r_failed;
        s_lat_fields = r_lat_fields;
        s_run_fields = r_run_fields;
        skip         = 1'b0;
        idx          = 2'd0;
        is_digit     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        prod = ({4'b0, r_accum} << 3) + ({4'b0, r_accum} << 1) + {{NUM_W{1'b0}}, c[3:0]};

        if (accept && !r_failed && r_phase != PH_DONE && c != CHAR_NUL) begin
            if (r_phase == PH_START) begin
                s_phase = PH_MAJOR;
                if (c == CHAR_V) begin
                    skip = 1'b1;
                end else if (needs_v) begin
                    s_failed = 1'b1;
                    skip     = 1'b1;
                end
            end
            if (!skip) begin
                idx = s_phase[1:0] - 2'd1;
                if (is_digit) begin
                    if (r_flags == FLAG_LEAD_ZERO || prod[NUM_W+3:NUM_W] != 4'd0) begin
                        s_failed = 1'b1;
                    end else begin
                        if (!r_flags[0]) begin
                            s_flags = (c == CHAR_ZERO) ? FLAG_LEAD_ZERO : FLAG_DIGIT;
                        end
                        s_accum = prod[NUM_W-1:0];
                    end
                end else if (!r_flags[0]) begin
                    s_failed = 1'b1;
                end else if (s_phase != PH_PATCH && c == CHAR_DOT) begin
                    if (!i_in.string_sel) begin
                        s_lat_fields[idx] = r_accum;
                    end else begin
                        s_run_fields[idx[0]] = r_accum;
                    end
                    s_phase = (s_phase == PH_MAJOR) ? PH_MINOR : PH_PATCH;
                    s_accum = '0;
                    s_flags = FLAG_NONE;
                end else if (s_phase == PH_PATCH && c == CHAR_DASH && allow_sfx) begin
                    if (!i_in.string_sel) begin
                        s_lat_fields[idx] = r_accum;
                    end
                    s_phase = PH_DONE;
                end else begin
                    s_failed = 1'b1;
                end
            end
        end

        // a nul byte or the last byte closes the string if it is still open
        do_end = accept && !s_failed && s_phase != PH_DONE
                 && (c == CHAR_NUL || i_in.last_byte);
        if (do_end) begin
            if (s_phase == PH_PATCH && s_flags[0]) begin
                if (!i_in.string_sel) begin
                    s_lat_fields[2] = s_accum;
                end
                s_phase = PH_DONE;
            end else begin
                s_failed = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- restart and result
    always_comb begin
        logic ok;

        n_phase  = s_phase;
        n_accum  = s_accum;
        n_flags  = s_flags;
        n_failed = s_failed;
        n_lat_ok = r_lat_ok;
        res_fire = 1'b0;
        res_data = '0;
        ok       = !s_failed && s_phase == PH_DONE;

        if (accept && i_in.last_byte) begin
            n_phase  = PH_START;
            n_accum  = '0;
            n_flags  = FLAG_NONE;
            n_failed = 1'b0;
            if (!i_in.string_sel) begin
                n_lat_ok = ok;
            end else begin
                res_fire               = 1'b1;
                res_data.latest_valid  = r_lat_ok;
                res_data.running_valid = ok;
                if (ok && r_lat_ok) begin
                    priority if (s_lat_fields[0] != s_run_fields[0]) begin
                        res_data.is_newer = s_lat_fields[0] > s_run_fields[0];
                    end else if (s_lat_fields[1] != s_run_fields[1]) begin
                        res_data.is_newer = s_lat_fields[1] > s_run_fields[1];
                    end else begin
                        res_data.is_newer = s_lat_fields[2] > s_accum;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_accum      <= '0;
            r_flags      <= FLAG_NONE;
            r_failed     <= 1'b0;
            r_lat_ok     <= 1'b0;
            r_lat_fields <= '{default: '0};
            r_run_fields <= '{default: '0};
        end else begin
            r_phase      <= n_phase;
            r_accum      <= n_accum;
            r_flags      <= n_flags;
            r_failed     <= n_failed;
            r_lat_ok     <= n_lat_ok;
            r_lat_fields <= s_lat_fields;
            r_run_fields <= s_run_fields;
        end
    end

    // ---------------------------------------------------------------- output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is stalled, so only the skid entry can move
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out <= r_skid;
            end
        end else if (res_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out <= res_data;
            end else begin
                r_skid <= res_data;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.is_newer      = r_out.is_newer;
    assign o_out.latest_valid  = r_out.latest_valid;
    assign o_out.running_valid = r_out.running_valid;

    // ---------------------------------------------------------------- checks
    `SSC_ASSERT(a_skid_implies_main, r_skid_valid |-> r_out_valid)
    `SSC_ASSERT(a_skid_drains, (r_skid_valid && o_out.ready) |=> !r_skid_valid)
    `SSC_NEVER(a_newer_needs_both_valid, r_out_valid && r_out.is_newer && !(r_out.latest_valid && r_out.running_valid))
    `SSC_ASSERT(a_restart_after_last, (accept && i_in.last_byte) |=> (r_phase == PH_START && !r_failed && r_flags == FLAG_NONE))

endmodule
